@@ rtl/dgb_pkg.sv @@
// Shared types and constants for the disk Gaussian blur block.
package dgb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int KSIZE      = 7;

  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int WGT_W   = 12;
  localparam int WIDTH_W = 12;
  localparam int HGT_W   = 13;
  localparam int ROW_W   = 12;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int PTR_W   = $clog2(MAX_WIDTH - 1);
  localparam int CNT_W   = $clog2(3 * MAX_WIDTH + 4);
  localparam int PROD_W  = CH_W + WGT_W;
  localparam int ROWS_W  = PROD_W + 3;
  localparam int SUM_W   = ROWS_W + 3;
  localparam int CFG_DW  = 13;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [KSIZE*KSIZE-1:0] mask;
    logic                   last;
  } tap_ctl_t;

  // Q0.16 weights, row = dy + 3, column = dx + 3; zero marks no tap
  localparam logic [WGT_W-1:0] KERN_W [KSIZE][KSIZE] = '{
    '{12'd0,    12'd0,    12'd0,    12'd2022, 12'd0,    12'd0,    12'd0},
    '{12'd0,    12'd2061, 12'd2201, 12'd2259, 12'd2201, 12'd2061, 12'd0},
    '{12'd0,    12'd2201, 12'd2411, 12'd2525, 12'd2411, 12'd2201, 12'd0},
    '{12'd2022, 12'd2259, 12'd2525, 12'd2821, 12'd2525, 12'd2259, 12'd2022},
    '{12'd0,    12'd2201, 12'd2411, 12'd2525, 12'd2411, 12'd2201, 12'd0},
    '{12'd0,    12'd2061, 12'd2201, 12'd2259, 12'd2201, 12'd2061, 12'd0},
    '{12'd0,    12'd0,    12'd0,    12'd2022, 12'd0,    12'd0,    12'd0}
  };

endpackage

@@ rtl/dgb_row_cell.sv @@
// One window row: a line buffer of width-1 entries feeding a seven-tap shift row.
module dgb_row_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      shift_i,
  input  logic                      bypass_i,
  input  logic [dgb_pkg::PTR_W-1:0] addr_i,
  input  dgb_pkg::pix_t             up_i,
  output dgb_pkg::pix_t             taps_o [dgb_pkg::KSIZE]
);
  import dgb_pkg::*;

  pix_t mem [MAX_WIDTH-1];
  pix_t rd_q;
  pix_t byp_q;
  logic bypass_q;
  pix_t row_q [KSIZE-1];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rd_q          <= mem[addr_i];
      mem[addr_i]   <= up_i;
      byp_q         <= up_i;
      bypass_q      <= bypass_i;
    end
  end

  assign taps_o[KSIZE-1] = bypass_q ? byp_q : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < KSIZE - 1; j++) row_q[j] <= '0;
    end else if (shift_i) begin
      for (int j = 0; j < KSIZE - 1; j++) row_q[j] <= taps_o[j+1];
    end
  end

  for (genvar j = 0; j < KSIZE - 1; j++) begin : g_tap
    assign taps_o[j] = row_q[j];
  end

endmodule

@@ rtl/dgb_tap_sum.sv @@
// Weighted tap sum: products, row sums, final sum with shift and clamp.
module dgb_tap_sum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  dgb_pkg::tap_ctl_t    ctl_i,
  input  dgb_pkg::pix_t        win_i [dgb_pkg::KSIZE][dgb_pkg::KSIZE],
  output logic                 valid_o,
  input  logic                 ready_i,
  output dgb_pkg::pix_t        pix_o,
  output logic                 last_o
);
  import dgb_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic l1_q, l2_q;
  logic [PROD_W-1:0] prod_q [3][KSIZE][KSIZE];
  logic [ROWS_W-1:0] rsum_q [3][KSIZE];
  logic [ROWS_W-1:0] rsum_d [3][KSIZE];
  pix_t              pix_d;
  pix_t              pix_q;
  logic              l3_q;

  assign en3     = !v3_q || ready_i;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      l1_q <= ctl_i.last;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < KSIZE; i++) begin
          for (int j = 0; j < KSIZE; j++) begin
            prod_q[c][i][j] <= ctl_i.mask[i*KSIZE+j]
                ? PROD_W'(KERN_W[i][j]) * PROD_W'(win_i[i][j][c*CH_W +: CH_W])
                : '0;
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < KSIZE; i++) begin
        rsum_d[c][i] = '0;
        for (int j = 0; j < KSIZE; j++) begin
          rsum_d[c][i] = rsum_d[c][i] + ROWS_W'(prod_q[c][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      l2_q   <= l1_q;
      rsum_q <= rsum_d;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    logic [SUM_W-17:0] r;
    pix_d = '0;
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int i = 0; i < KSIZE; i++) acc = acc + SUM_W'(rsum_q[c][i]);
      r = acc[SUM_W-1:16];
      pix_d[c*CH_W +: CH_W] = (r > (SUM_W-16)'(255)) ? 8'hFF : r[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pix_q <= pix_d;
      l3_q  <= l2_q;
    end
  end

  assign valid_o = v3_q;
  assign pix_o   = pix_q;
  assign last_o  = l3_q;

endmodule

@@ rtl/disk_gaussian_blur_rgb_unit.sv @@
// Disk Gaussian blur over an RGB pixel stream: top level.
//
// Pixels enter on the s_axis channel in raster order, one transaction per
// item; tuser set marks a flush item with no pixel (taken as black). Blurred
// pixels leave on m_axis, tlast marking the last pixel of the frame. Each
// result belongs to the item 3*width+3 transactions earlier, so after the
// last pixel of a frame 3*width+3 flush items drain the remaining results.
// Width and height are written over the cfg channel (index 0 width, index
// 1 height) by the user, only while the block is idle: the block itself
// does not enforce this. cfg_ready_o is always high. The block takes one
// item per cycle while input ready is high. A result passes in turn through
// the registered 7x7 window row cells, then products, row sums and the final
// sum with clamp. Seven row cells each hold a line buffer memory that is
// read and written once per item; the newest row bypasses its own. Reset
// clears counters and the window; line buffer contents need no clear. When
// the receiver stalls, the output holds and bubbles in the pipeline fill
// up first; input ready falls only once all four stages are full.
module disk_gaussian_blur_rgb_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [23:0]                s_axis_tdata,   // red_in, green_in, blue_in
  input  logic                       s_axis_tuser,   // opcode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [23:0]                m_axis_tdata,   // red_out, green_out, blue_out
  output logic                       m_axis_tlast,   // frame_end
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [dgb_pkg::CFG_DW-1:0] cfg_data_i
);
  import dgb_pkg::*;

  logic [WIDTH_W-1:0] width_q;
  logic [HGT_W-1:0]   height_q;
  logic [WIDTH_W:0]   w_eff;
  logic [HGT_W-1:0]   h_eff;
  logic [CNT_W-1:0]   lag;
  logic [CNT_W-1:0]   cnt_q;
  logic [ROW_W-1:0]   out_row_q;
  logic [COL_W-1:0]   out_col_q;
  logic [PTR_W-1:0]   ptr_q;
  logic               accept, produce, last, v0_q, sum_ready;
  tap_ctl_t           ctl_d, ctl_q;
  pix_t               pix_in;
  pix_t               win [KSIZE][KSIZE];
  pix_t               taps [KSIZE][KSIZE];
  pix_t               pix_out;
  logic               bypass;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_W'(640);
      height_q <= HGT_W'(480);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) w_eff = (WIDTH_W+1)'(1);
    else if ({1'b0, width_q} > (WIDTH_W+1)'(MAX_WIDTH)) w_eff = (WIDTH_W+1)'(MAX_WIDTH);
    else w_eff = {1'b0, width_q};
    if (height_q == '0) h_eff = HGT_W'(1);
    else if (height_q > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = height_q;
  end

  assign lag     = CNT_W'(w_eff) + CNT_W'({w_eff, 1'b0}) + CNT_W'(3);
  assign produce = cnt_q >= lag;
  assign last    = ({1'b0, out_row_q} > h_eff - HGT_W'(1))
                || (({1'b0, out_row_q} == h_eff - HGT_W'(1))
                    && ((WIDTH_W+1)'(out_col_q) >= w_eff - (WIDTH_W+1)'(1)));

  assign s_axis_tready = !v0_q || sum_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pix_in        = s_axis_tuser ? '0 : s_axis_tdata;
  assign bypass        = (w_eff == (WIDTH_W+1)'(1));

  // taps of the kernel that fall inside the image
  always_comb begin
    logic [ROW_W:0] r;
    logic [COL_W:0] c;
    ctl_d.last = last;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        r = {1'b0, out_row_q} + (ROW_W+1)'(i);
        c = {1'b0, out_col_q} + (COL_W+1)'(j);
        ctl_d.mask[i*KSIZE+j] = (r >= (ROW_W+1)'(3))
            && (HGT_W'(r - (ROW_W+1)'(3)) < h_eff)
            && (c >= (COL_W+1)'(3))
            && ((WIDTH_W+1)'(c - (COL_W+1)'(3)) < w_eff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      ptr_q     <= '0;
      v0_q      <= 1'b0;
    end else begin
      if (s_axis_tready) v0_q <= accept && produce;
      if (accept) begin
        if ((w_eff <= (WIDTH_W+1)'(2))
            || ((WIDTH_W+1)'(ptr_q) >= w_eff - (WIDTH_W+1)'(2))) begin
          ptr_q <= '0;
        end else begin
          ptr_q <= ptr_q + PTR_W'(1);
        end
        if (!produce) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else if (last) begin
          cnt_q     <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
        end else if ((WIDTH_W+1)'(out_col_q) + (WIDTH_W+1)'(1) >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) ctl_q <= ctl_d;
  end

  // row KSIZE-1 takes the newest item; each row above reads the one below
  for (genvar i = 0; i < KSIZE; i++) begin : g_row
    pix_t row_taps [KSIZE];
    if (i == KSIZE - 1) begin : g_new
      dgb_row_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (accept),
        .bypass_i (1'b1),
        .addr_i   (ptr_q),
        .up_i     (pix_in),
        .taps_o   (row_taps)
      );
    end else begin : g_old
      dgb_row_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (accept),
        .bypass_i (bypass),
        .addr_i   (ptr_q),
        .up_i     (taps[i+1][KSIZE-1]),
        .taps_o   (row_taps)
      );
    end
    for (genvar j = 0; j < KSIZE; j++) begin : g_col
      assign taps[i][j] = row_taps[j];
      assign win[i][j]  = taps[i][j];
    end
  end

  dgb_tap_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .ready_o (sum_ready),
    .ctl_i   (ctl_q),
    .win_i   (win),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .pix_o   (pix_out),
    .last_o  (m_axis_tlast)
  );

  // channels keep the input byte order, matching the bus packing
  assign m_axis_tdata = pix_out;

endmodule

@@ rtl/dgb_checker.sv @@
// Port-level checks for the blur top level, bound to it.
module dgb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled output");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind disk_gaussian_blur_rgb_unit dgb_checker u_dgb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready_o   (cfg_ready_o)
);
